/* rtl/rad_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_pkg: shared types and constants
// Operation codes, field widths and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package rad_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int KIND_W = 2;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;

  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIV     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RED     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RED_ALT = 2'd3;  // decodes as reduce

  // datapath micro-operations
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;  // capture operands, magnitudes, signs
  localparam logic [3:0] OP_GSET1 = 4'd2;  // gcd x,y <- |a_den|,|b_den|
  localparam logic [3:0] OP_GSTEP = 4'd3;  // one binary gcd step
  localparam logic [3:0] OP_DSET1 = 4'd4;  // divider: |a_den| / g and |b_den| / g
  localparam logic [3:0] OP_DSTEP = 4'd5;  // one restoring division bit
  localparam logic [3:0] OP_MUL1  = 4'd6;  // add/div products
  localparam logic [3:0] OP_SUM   = 4'd7;  // signed sum for add
  localparam logic [3:0] OP_GSET2 = 4'd8;  // gcd x,y <- result num,den
  localparam logic [3:0] OP_DSET2 = 4'd9;  // divider: num / g and den / g
  localparam logic [3:0] OP_DONE  = 4'd10; // capture result

  typedef struct packed {
    logic [3:0] op;
  } rad_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic err;
    logic [KIND_W-1:0] kind;
  } rad_sts_t;

endpackage

/* rtl/rad_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_datapath: operand registers, binary gcd and serial divider
// Executes one micro-operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module rad_datapath #(
  parameter int OPERAND_WIDTH = rad_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                          clk,
  input  rad_pkg::rad_cmd_t             cmd,
  input  logic [rad_pkg::KIND_W-1:0]    in_kind,
  input  logic [4*OPERAND_WIDTH-1:0]    in_ops,
  output rad_pkg::rad_sts_t             sts,
  output logic [rad_pkg::RES_NUM_W-1:0] res_num,
  output logic [rad_pkg::RES_DEN_W-1:0] res_den,
  output logic                          status
);
  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W + 2;          // product / sum magnitudes
  localparam int CW = $clog2(MW + 1);

  logic [rad_pkg::KIND_W-1:0] kind;
  logic [W:0] man, mad, mbn, mbd;
  logic an, ad, bn, bd, neg, err;
  logic [MW-1:0] gx, gy, g;
  logic [CW-1:0] gsh;
  logic [MW-1:0] r0, r1, dv, n0, n1;
  logic [CW-1:0] dcnt;
  logic [MW-1:0] tn, tb, rden;

  function automatic logic [W:0] mag(input logic [W-1:0] v);
    return v[W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
  endfunction

  logic [MW-1:0] r0s, r1s;
  always_comb begin
    r0s = {r0[MW-2:0], n0[MW-1]};
    r1s = {r1[MW-2:0], n1[MW-1]};
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rad_pkg::OP_LOAD: begin
        kind <= in_kind;
        man <= mag(in_ops[W-1:0]);     an <= in_ops[W-1];
        mad <= mag(in_ops[2*W-1:W]);   ad <= in_ops[2*W-1];
        mbn <= mag(in_ops[3*W-1:2*W]); bn <= in_ops[3*W-1];
        mbd <= mag(in_ops[4*W-1:3*W]); bd <= in_ops[4*W-1];
      end
      rad_pkg::OP_GSET1: begin
        gx <= MW'(mad); gy <= MW'(mbd); gsh <= '0;
        // reduce only checks the first denominator
        err <= (kind != rad_pkg::KIND_ADD && kind != rad_pkg::KIND_DIV) ?
               (mad == '0) :
               ((mad == '0) || (mbd == '0) ||
                ((kind == rad_pkg::KIND_DIV) && (mbn == '0)));
      end
      rad_pkg::OP_GSET2: begin
        gx <= tn; gy <= rden; gsh <= '0;
      end
      rad_pkg::OP_GSTEP: begin
        if (gx == '0) g <= gy << gsh;
        else if (gy == '0) g <= gx << gsh;
        else if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1; gy <= gy >> 1; gsh <= gsh + 1'b1;
        end else if (!gx[0]) gx <= gx >> 1;
        else if (!gy[0]) gy <= gy >> 1;
        else if (gx >= gy) gx <= (gx - gy) >> 1;
        else gy <= (gy - gx) >> 1;
      end
      rad_pkg::OP_DSET1: begin
        n0 <= MW'(mad); n1 <= MW'(mbd); dv <= g;
        r0 <= '0; r1 <= '0; dcnt <= '0;
      end
      rad_pkg::OP_DSET2: begin
        n0 <= tn; n1 <= rden; dv <= g;
        r0 <= '0; r1 <= '0; dcnt <= '0;
      end
      rad_pkg::OP_DSTEP: begin
        n0 <= {n0[MW-2:0], (r0s >= dv)};
        n1 <= {n1[MW-2:0], (r1s >= dv)};
        r0 <= (r0s >= dv) ? r0s - dv : r0s;
        r1 <= (r1s >= dv) ? r1s - dv : r1s;
        dcnt <= dcnt + 1'b1;
      end
      rad_pkg::OP_MUL1: begin
        if (kind == rad_pkg::KIND_ADD) begin
          tn   <= MW'(man * n1[W:0]);
          tb   <= MW'(mbn * n0[W:0]);
          rden <= MW'(n0[W:0] * mbd);
        end else if (kind == rad_pkg::KIND_DIV) begin
          tn <= MW'(man * mbd); rden <= MW'(mad * mbn);
          neg <= (an ^ bd) ^ (ad ^ bn);
        end else begin
          tn <= MW'(man); rden <= MW'(mad); neg <= an ^ ad;
        end
      end
      rad_pkg::OP_SUM: begin
        if (kind == rad_pkg::KIND_ADD) begin
          if ((an ^ ad) == (bn ^ bd)) begin
            tn <= tn + tb; neg <= an ^ ad;
          end else if (tn >= tb) begin
            tn <= tn - tb; neg <= an ^ ad;
          end else begin
            tn <= tb - tn; neg <= bn ^ bd;
          end
        end
      end
      rad_pkg::OP_DONE: begin
        status <= err;
        if (err) begin
          res_num <= '0; res_den <= '0;
        end else begin
          res_num <= (neg && n0 != '0) ? rad_pkg::RES_NUM_W'(-n0)
                                       : rad_pkg::RES_NUM_W'(n0);
          res_den <= rad_pkg::RES_DEN_W'(n1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.gcd_done = (gx == '0) || (gy == '0);
    sts.div_done = (dcnt == CW'(MW));
    sts.err = err;
    sts.kind = kind;
  end
endmodule

/* rtl/rad_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_ctrl: sequencing state machine
// Steps the datapath through load, gcd, divide, multiply, sum and reduce phases.
// ----------------------------------------------------------------------------
module rad_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_fire,
  input  rad_pkg::rad_sts_t sts,
  output rad_pkg::rad_cmd_t cmd,
  output logic              in_ready,
  output logic              out_valid
);
  localparam logic [3:0] S_IDLE = 4'd0, S_G1S = 4'd1, S_G1 = 4'd2, S_D1S = 4'd3,
                         S_D1 = 4'd4, S_MUL = 4'd5, S_SUM = 4'd6, S_G2S = 4'd7,
                         S_G2 = 4'd8, S_D2S = 4'd9, S_D2 = 4'd10, S_DONE = 4'd11,
                         S_OUT = 4'd12;
  logic [3:0] state, state_next;
  logic gcd_fin;

  // an extra GSTEP latches g after an operand reaches zero
  always_ff @(posedge clk) begin
    if (rst) gcd_fin <= 1'b0;
    else gcd_fin <= (state == S_G1 || state == S_G2) && sts.gcd_done && !gcd_fin;
  end

  always_comb begin
    state_next = state;
    cmd.op = rad_pkg::OP_NONE;
    unique case (state)
      S_IDLE: if (in_fire) begin cmd.op = rad_pkg::OP_LOAD; state_next = S_G1S; end
      S_G1S: begin cmd.op = rad_pkg::OP_GSET1; state_next = S_G1; end
      S_G1: begin
        cmd.op = rad_pkg::OP_GSTEP;
        if (gcd_fin) begin cmd.op = rad_pkg::OP_NONE; state_next = S_D1S; end
      end
      S_D1S: begin cmd.op = rad_pkg::OP_DSET1; state_next = S_D1; end
      S_D1: begin
        cmd.op = rad_pkg::OP_DSTEP;
        if (sts.div_done) begin cmd.op = rad_pkg::OP_NONE; state_next = S_MUL; end
      end
      S_MUL: begin cmd.op = rad_pkg::OP_MUL1; state_next = S_SUM; end
      S_SUM: begin cmd.op = rad_pkg::OP_SUM; state_next = S_G2S; end
      S_G2S: begin cmd.op = rad_pkg::OP_GSET2; state_next = S_G2; end
      S_G2: begin
        cmd.op = rad_pkg::OP_GSTEP;
        if (gcd_fin) begin cmd.op = rad_pkg::OP_NONE; state_next = S_D2S; end
      end
      S_D2S: begin cmd.op = rad_pkg::OP_DSET2; state_next = S_D2; end
      S_D2: begin
        cmd.op = rad_pkg::OP_DSTEP;
        if (sts.div_done) begin cmd.op = rad_pkg::OP_NONE; state_next = S_DONE; end
      end
      S_DONE: begin cmd.op = rad_pkg::OP_DONE; state_next = S_OUT; end
      S_OUT: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready and valid together");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_fire |=> out_valid) else $error("result dropped");
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_G1S) else $error("load not followed by gcd");
endmodule

/* rtl/rational_add_divide_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_add_divide_reduce: rational add / divide / reduce unit
// Returns one result fraction in lowest terms per request.
// ----------------------------------------------------------------------------
// One request at a time. Each request runs two binary gcd reductions, whose
// steps each drop at least one bit of the pair, and two bit-serial dividers
// that develop one quotient bit per step across the full product width. The
// result is held on m_axis until taken; s_axis_tready is high only when idle.
// Zero denominators (operand or result) give 0/0 with status 1.
module rational_add_divide_reduce #(
  parameter int OPERAND_WIDTH = rad_pkg::OPERAND_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser: kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  // tdata: a_num, a_den, b_num, b_den (OPERAND_WIDTH each, low to high), zero pad
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: res_num[32:0], res_den[63:33], status[64], zero pad
  output logic [71:0] m_axis_tdata
);
  rad_pkg::rad_cmd_t cmd;
  rad_pkg::rad_sts_t sts;
  logic [rad_pkg::RES_NUM_W-1:0] res_num;
  logic [rad_pkg::RES_DEN_W-1:0] res_den;
  logic status;

  rad_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(s_axis_tvalid && s_axis_tready),
    .out_fire(m_axis_tvalid && m_axis_tready),
    .sts, .cmd,
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
  );

  rad_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk, .cmd, .in_kind(s_axis_tuser),
    .in_ops(s_axis_tdata[4*OPERAND_WIDTH-1:0]),
    .sts, .res_num, .res_den, .status
  );

  assign m_axis_tdata = {7'd0, status, res_den, res_num};
endmodule
